/* rtl/core/diq_pkg.sv */
package diq_pkg;

    // Default ring size; the top level hands its parameter down to the back end.
    localparam int RING_SLOTS_DEF = 16;

    localparam int XLEN      = 32;
    localparam int CFG_W     = 5;   // widest configuration register
    localparam int CFG_IDX_W = 1;
    localparam int OCC_W     = 5;
    localparam int COUNT_W   = 2;

    localparam logic [CFG_W-1:0] DEPTH_LIMIT_RST = 5'd8;
    localparam logic             PAIR_POLICY_RST = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_LIMIT = 1'b0,
        REG_PAIR_POLICY = 1'b1
    } cfg_reg_t;

    // RV32 major opcodes and funct7 codes used by the pairing rules
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_FENCE  = 7'h0f;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_SR     = 3'd5;

    // Predecode flags, computed once when a packet enters
    typedef struct packed {
        logic alu;
        logic lsu;
        logic cfi;
        logic dest_wr;
        logic src1_rd;
        logic src2_rd;
        logic single_first;
        logic single_second;
    } pre_t;

    typedef struct packed {
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] word;
        logic            taken;
        pre_t            pre;
    } slot_t;

    typedef struct packed {
        logic [COUNT_W-1:0] push_count;
        slot_t              first;
        slot_t              second;
        logic               consumer_stall;
    } cmd_t;

    typedef struct packed {
        logic               accepted;
        logic [COUNT_W-1:0] issue_count;
        logic [XLEN-1:0]    pc_a;
        logic [XLEN-1:0]    word_a;
        logic [XLEN-1:0]    pc_b;
        logic [XLEN-1:0]    word_b;
        logic [OCC_W-1:0]   occupancy;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] depth_limit;
        logic             pair_policy;
    } cfg_t;

endpackage

/* rtl/core/diq_ram.sv */
module diq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/core/diq_front.sv */
module diq_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [diq_pkg::COUNT_W-1:0]       push_count,
    input  logic [diq_pkg::XLEN-1:0]          pc_first,
    input  logic [diq_pkg::XLEN-1:0]          word_first,
    input  logic                              taken_first,
    input  logic [diq_pkg::XLEN-1:0]          pc_second,
    input  logic [diq_pkg::XLEN-1:0]          word_second,
    input  logic                              taken_second,
    input  logic                              consumer_stall,
    output logic                              cmd_valid,
    output diq_pkg::cmd_t                     cmd,
    input  logic                              cmd_pop
);

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_FULL  = 2'd2;

    diq_pkg::cmd_t fifo_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    diq_pkg::cmd_t entry_in;
    logic          push;

    function automatic diq_pkg::pre_t classify(input logic [diq_pkg::XLEN-1:0] w);
        logic [6:0]    op;
        logic [2:0]    f3;
        logic [6:0]    f7;
        logic          r, ia, ld, st, br, jal, jalr, sys, fence, upper;
        logic          muldiv, illegal, alt, odd_r, shimm, base_sh, odd_i;
        diq_pkg::pre_t p;
        op      = w[6:0];
        f3      = w[14:12];
        f7      = w[31:25];
        r       = op == diq_pkg::OP_REG;
        ia      = op == diq_pkg::OP_IMM;
        ld      = op == diq_pkg::OP_LOAD;
        st      = op == diq_pkg::OP_STORE;
        br      = op == diq_pkg::OP_BRANCH;
        jal     = op == diq_pkg::OP_JAL;
        jalr    = op == diq_pkg::OP_JALR;
        sys     = op == diq_pkg::OP_SYSTEM;
        fence   = op == diq_pkg::OP_FENCE;
        upper   = (op == diq_pkg::OP_LUI) || (op == diq_pkg::OP_AUIPC);
        muldiv  = r && (f7 == diq_pkg::F7_MULDIV);
        illegal = w[1:0] != 2'b11;
        alt     = (f7 == diq_pkg::F7_ALT) && ((f3 == diq_pkg::F3_ADD) || (f3 == diq_pkg::F3_SR));
        odd_r   = r && (f7 != diq_pkg::F7_BASE) && !alt;
        shimm   = f3[1:0] == 2'b01;
        base_sh = (f7 == diq_pkg::F7_BASE) || ((f7 == diq_pkg::F7_ALT) && (f3 == diq_pkg::F3_SR));
        odd_i   = ia && shimm && !base_sh;
        p.alu           = (r && !muldiv) || ia || upper;
        p.lsu           = ld || st;
        p.cfi           = br || jal || jalr;
        p.dest_wr       = r || ia || ld || upper || jal || jalr || sys;
        p.src1_rd       = r || ia || ld || st || br || jalr;
        p.src2_rd       = r || st || br;
        p.single_second = sys || fence || illegal || odd_r || odd_i;
        p.single_first  = jalr || p.single_second;
        return p;
    endfunction

    always_comb
    begin
        entry_in.push_count   = push_count;
        entry_in.first.pc     = pc_first;
        entry_in.first.word   = word_first;
        entry_in.first.taken  = taken_first;
        entry_in.first.pre    = classify(word_first);
        entry_in.second.pc    = pc_second;
        entry_in.second.word  = word_second;
        entry_in.second.taken = taken_second;
        entry_in.second.pre   = classify(word_second);
        entry_in.consumer_stall = consumer_stall;
    end

    assign in_ready  = fill_reg != FILL_FULL;
    assign push      = in_valid && in_ready;
    assign cmd_valid = fill_reg != FILL_EMPTY;
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            fill_reg    <= FILL_EMPTY;
            fifo_reg[0] <= '0;
            fifo_reg[1] <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_reg[wr_ptr_reg] <= entry_in;
                wr_ptr_reg           <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

endmodule

/* rtl/core/diq_back.sv */
module diq_back #(
    parameter int RING_SLOTS = diq_pkg::RING_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  diq_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    input  diq_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output diq_pkg::result_t result
);

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int CNT_W  = $clog2(RING_SLOTS + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CMP_W  = ((CNT_W > diq_pkg::CFG_W) ? CNT_W : diq_pkg::CFG_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WR2
    } state_t;

    state_t           state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [SLOT_W-1:0] tail2_reg, tail2_next;
    diq_pkg::cmd_t     cmd_reg, cmd_next;
    logic              out_valid_reg, out_valid_next;
    diq_pkg::result_t  result_reg, result_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    diq_pkg::slot_t    ram_wdata;
    logic [SLOT_W-1:0] head_plus1;
    diq_pkg::slot_t    slot_a, slot_b;

    logic                       can_issue;
    logic [diq_pkg::COUNT_W-1:0] deq;
    logic [SUM_W-1:0]           head_sum, tail_sum;
    logic [SLOT_W-1:0]          head_new, tail_addr, tail_plus1;
    logic [CNT_W-1:0]           held_after, held_fin;
    logic [CMP_W-1:0]           limit, want;
    logic                       push_ok, acc, push_two;

    function automatic logic can_pair(input diq_pkg::slot_t a, input diq_pkg::slot_t b);
        logic [4:0] rd_a, rs1_b, rs2_b;
        logic       wr, raw1, raw2, bypass, ok;
        rd_a   = a.word[11:7];
        rs1_b  = b.word[19:15];
        rs2_b  = b.word[24:20];
        wr     = a.pre.dest_wr && (rd_a != 5'd0);
        raw1   = wr && b.pre.src1_rd && (rs1_b == rd_a);
        raw2   = wr && b.pre.src2_rd && (rs2_b == rd_a);
        bypass = a.pre.alu && b.pre.lsu && b.pre.src2_rd && raw2 && !raw1;
        ok     = (b.pc == a.pc + 32'd4) && !a.taken
                 && !a.pre.single_first && !b.pre.single_second;
        ok     = ok && !((raw1 || raw2) && !bypass);
        ok     = ok && (a.pre.alu || a.pre.lsu || a.pre.cfi)
                    && (b.pre.alu || b.pre.lsu || b.pre.cfi);
        ok     = ok && !(a.pre.lsu && b.pre.lsu) && !(a.pre.cfi && b.pre.cfi);
        return ok;
    endfunction

    // The two head entries are read every cycle; the read is registered, so the
    // data seen in S_EVAL belongs to the head held while in S_IDLE.
    assign head_plus1 = (head_reg == SLOT_W'(RING_SLOTS - 1)) ? '0 : head_reg + SLOT_W'(1);

    diq_ram #(
        .WIDTH ($bits(diq_pkg::slot_t)),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (head_reg),
        .raddr_b (head_plus1),
        .rdata_a (slot_a),
        .rdata_b (slot_b)
    );

    always_comb
    begin
        can_issue = (held_reg != '0) && !cmd_reg.consumer_stall;
        if (!can_issue)
        begin
            deq = 2'd0;
        end
        else if (held_reg == CNT_W'(1))
        begin
            deq = 2'd1;
        end
        else if (cfg.pair_policy || can_pair(slot_a, slot_b))
        begin
            deq = 2'd2;
        end
        else
        begin
            deq = 2'd1;
        end

        head_sum   = SUM_W'(head_reg) + SUM_W'(deq);
        head_new   = (head_sum >= SUM_W'(RING_SLOTS)) ? SLOT_W'(head_sum - SUM_W'(RING_SLOTS))
                                                      : SLOT_W'(head_sum);
        held_after = held_reg - CNT_W'(deq);

        limit    = (CMP_W'(cfg.depth_limit) > CMP_W'(RING_SLOTS)) ? CMP_W'(RING_SLOTS)
                                                                  : CMP_W'(cfg.depth_limit);
        want     = CMP_W'(held_after) + CMP_W'(cmd_reg.push_count);
        push_ok  = (cmd_reg.push_count == 2'd1) || (cmd_reg.push_count == 2'd2);
        push_two = cmd_reg.push_count == 2'd2;
        acc      = push_ok && (want <= limit);
        held_fin = acc ? CNT_W'(want) : held_after;

        tail_sum   = SUM_W'(head_new) + SUM_W'(held_after);
        tail_addr  = (tail_sum >= SUM_W'(RING_SLOTS)) ? SLOT_W'(tail_sum - SUM_W'(RING_SLOTS))
                                                      : SLOT_W'(tail_sum);
        tail_plus1 = (tail_addr == SLOT_W'(RING_SLOTS - 1)) ? '0 : tail_addr + SLOT_W'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        held_next      = held_reg;
        tail2_next     = tail2_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_addr;
        ram_wdata      = cmd_reg.first;
        cmd_pop        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // take the next packet once the result slot will be free
                if (cmd_valid && (!out_valid_reg || out_ready))
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                head_next               = head_new;
                held_next               = acc ? held_after + CNT_W'(1) : held_after;
                result_next.accepted    = acc;
                result_next.issue_count = deq;
                result_next.pc_a        = (deq != 2'd0) ? slot_a.pc : '0;
                result_next.word_a      = (deq != 2'd0) ? slot_a.word : '0;
                result_next.pc_b        = (deq == 2'd2) ? slot_b.pc : '0;
                result_next.word_b      = (deq == 2'd2) ? slot_b.word : '0;
                result_next.occupancy   = diq_pkg::OCC_W'(held_fin);
                out_valid_next          = 1'b1;
                ram_we                  = acc;
                tail2_next              = tail_plus1;
                state_next              = (acc && push_two) ? S_WR2 : S_IDLE;
            end
            S_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = tail2_reg;
                ram_wdata  = cmd_reg.second;
                held_next  = held_reg + CNT_W'(1);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            tail2_reg     <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            tail2_reg     <= tail2_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_held_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(RING_SLOTS))
        else $error("ring holds more entries than slots");

    a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |=> out_valid_reg)
        else $error("evaluated packet produced no result");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_EVAL) || (state_reg == S_WR2)))
        else $error("ring written outside packet processing");

    a_second_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR2) |-> (held_reg < CNT_W'(RING_SLOTS)))
        else $error("second packet word written into a full ring");

endmodule

/* rtl/core/dual_issue_decode_queue_unit.sv */
// Dual-issue decode queue. Each transfer on the input channel carries a fetch
// packet of zero, one or two RV32 instructions plus a consumer stall flag, and
// yields exactly one transfer on the output channel. That result reports how
// many instructions left the head of the queue (zero, one or two, with their
// PCs and encodings; unused slots read zero), whether the packet was appended,
// and the occupancy afterwards. Removal happens before the append, so a packet
// may use the room freed in the same step. Two head entries issue together
// when the pairing rules allow it (sequential PCs, first not predicted taken,
// no forced-single opcodes, not two memory or two control-flow ops, no
// blocking read-after-write except a store-data bypass), or always when the
// pair policy register is 1. A packet is taken only whole and only when it
// fits under the depth limit (values above the ring size act as the ring size;
// zero refuses everything). Each packet takes the back end from S_IDLE to
// S_EVAL, then to S_WR2 when two instructions are appended, because the ring
// RAM has a single write port and a registered read of the two head entries.
// A two-entry command queue between the predecode front end and back end lets
// the input keep transferring, while the queue has room, as the back end works
// or a result waits for the output to be taken. Configuration writes are meant
// for idle periods only; both registers reset to depth limit 8 and pairing rules on.
module dual_issue_decode_queue_unit #(
    parameter int RING_SLOTS = diq_pkg::RING_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [diq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [diq_pkg::CFG_W-1:0]         cfg_data,
    // packet input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [diq_pkg::COUNT_W-1:0]       push_count,
    input  logic [diq_pkg::XLEN-1:0]          pc_first,
    input  logic [diq_pkg::XLEN-1:0]          word_first,
    input  logic                              taken_first,
    input  logic [diq_pkg::XLEN-1:0]          pc_second,
    input  logic [diq_pkg::XLEN-1:0]          word_second,
    input  logic                              taken_second,
    input  logic                              consumer_stall,
    // result output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [diq_pkg::COUNT_W-1:0]       issue_count,
    output logic [diq_pkg::XLEN-1:0]          issued_pc_a,
    output logic [diq_pkg::XLEN-1:0]          issued_word_a,
    output logic [diq_pkg::XLEN-1:0]          issued_pc_b,
    output logic [diq_pkg::XLEN-1:0]          issued_word_b,
    output logic [diq_pkg::OCC_W-1:0]         occupancy
);

    diq_pkg::cfg_t    cfg_reg;
    logic             cmd_valid;
    diq_pkg::cmd_t    cmd;
    logic             cmd_pop;
    diq_pkg::result_t result;

    // Configuration registers: written directly, no handshake, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_limit <= diq_pkg::DEPTH_LIMIT_RST;
            cfg_reg.pair_policy <= diq_pkg::PAIR_POLICY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                diq_pkg::REG_DEPTH_LIMIT: cfg_reg.depth_limit <= cfg_data;
                diq_pkg::REG_PAIR_POLICY: cfg_reg.pair_policy <= cfg_data[0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Front end: hold each transferred packet with its predecode flags in a
    // short queue so the input need not wait on the ring update while it has room.
    diq_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .push_count     (push_count),
        .pc_first       (pc_first),
        .word_first     (word_first),
        .taken_first    (taken_first),
        .pc_second      (pc_second),
        .word_second    (word_second),
        .taken_second   (taken_second),
        .consumer_stall (consumer_stall),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop)
    );

    // Back end: issue from the ring head, append the packet, register the result.
    diq_back #(
        .RING_SLOTS (RING_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign accepted      = result.accepted;
    assign issue_count   = result.issue_count;
    assign issued_pc_a   = result.pc_a;
    assign issued_word_a = result.word_a;
    assign issued_pc_b   = result.pc_b;
    assign issued_word_b = result.word_b;
    assign occupancy     = result.occupancy;

endmodule

/* dv/dual_issue_decode_queue_unit_test.sv */
`timescale 1ns / 1ps

module dual_issue_decode_queue_unit_test;

    localparam int RING_SIZE = diq_pkg::RING_SLOTS_DEF;

    // One fetch packet as it travels over the input channel
    typedef struct packed {
        logic [diq_pkg::COUNT_W-1:0] push_count;
        logic [diq_pkg::XLEN-1:0]    pc_first;
        logic [diq_pkg::XLEN-1:0]    word_first;
        logic                        taken_first;
        logic [diq_pkg::XLEN-1:0]    pc_second;
        logic [diq_pkg::XLEN-1:0]    word_second;
        logic                        taken_second;
        logic                        consumer_stall;
    } packet_t;

    // Instruction class as the pairing rules see it
    typedef struct packed {
        logic       alu;
        logic       lsu;
        logic       cfi;
        logic       dest_wr;
        logic       src1_rd;
        logic       src2_rd;
        logic       single_first;
        logic       single_second;
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
    } instr_class_t;

    // Mirror of the queue: predicts the issue result of every packet transfer
    // and checks the result transfers against it in order.
    class queue_scoreboard;
        logic [diq_pkg::XLEN-1:0]  pc_ring[RING_SIZE];
        logic [diq_pkg::XLEN-1:0]  word_ring[RING_SIZE];
        logic                      taken_ring[RING_SIZE];
        int unsigned               head;
        int unsigned               held;
        logic [diq_pkg::CFG_W-1:0] depth_limit;
        logic                      pair_all;
        diq_pkg::result_t          expected_issues[$];
        int unsigned               errors;

        function new();
            head = 0;
            held = 0;
            depth_limit = diq_pkg::DEPTH_LIMIT_RST;
            pair_all = diq_pkg::PAIR_POLICY_RST;
            errors = 0;
        endfunction

        function void configure(diq_pkg::cfg_reg_t idx, logic [diq_pkg::CFG_W-1:0] value);
            case (idx)
                diq_pkg::REG_DEPTH_LIMIT: depth_limit = value;
                diq_pkg::REG_PAIR_POLICY: pair_all = value[0];
                default: ;
            endcase
        endfunction

        function instr_class_t classify(logic [diq_pkg::XLEN-1:0] w);
            instr_class_t c;
            logic [6:0] op;
            logic [6:0] f7;
            logic [2:0] f3;
            logic is_r, is_imm, is_ld, is_st, is_br, is_jal, is_jalr, is_sys, fence_op;
            logic upper, muldiv, illegal, alt, odd_r, shimm, base_sh, odd_i;
            op = w[6:0];
            f3 = w[14:12];
            f7 = w[31:25];
            is_r = op == diq_pkg::OP_REG;
            is_imm = op == diq_pkg::OP_IMM;
            is_ld = op == diq_pkg::OP_LOAD;
            is_st = op == diq_pkg::OP_STORE;
            is_br = op == diq_pkg::OP_BRANCH;
            is_jal = op == diq_pkg::OP_JAL;
            is_jalr = op == diq_pkg::OP_JALR;
            is_sys = op == diq_pkg::OP_SYSTEM;
            fence_op = op == diq_pkg::OP_FENCE;
            upper = op == diq_pkg::OP_LUI || op == diq_pkg::OP_AUIPC;
            muldiv = is_r && f7 == diq_pkg::F7_MULDIV;
            illegal = w[1:0] != 2'b11;
            alt = f7 == diq_pkg::F7_ALT && (f3 == diq_pkg::F3_ADD || f3 == diq_pkg::F3_SR);
            odd_r = is_r && f7 != diq_pkg::F7_BASE && !alt;
            shimm = f3[1:0] == 2'b01;
            base_sh = f7 == diq_pkg::F7_BASE || (f7 == diq_pkg::F7_ALT && f3 == diq_pkg::F3_SR);
            odd_i = is_imm && shimm && !base_sh;
            c.alu = (is_r && !muldiv) || is_imm || upper;
            c.lsu = is_ld || is_st;
            c.cfi = is_br || is_jal || is_jalr;
            c.dest_wr = is_r || is_imm || is_ld || upper || is_jal || is_jalr || is_sys;
            c.src1_rd = is_r || is_imm || is_ld || is_st || is_br || is_jalr;
            c.src2_rd = is_r || is_st || is_br;
            c.rd = w[11:7];
            c.rs1 = w[19:15];
            c.rs2 = w[24:20];
            c.single_second = is_sys || fence_op || illegal || odd_r || odd_i;
            c.single_first = is_jalr || c.single_second;
            return c;
        endfunction

        function bit pairable(int unsigned sa, int unsigned sb);
            instr_class_t a;
            instr_class_t b;
            logic wr, raw1, raw2, bypass;
            a = classify(word_ring[sa]);
            b = classify(word_ring[sb]);
            if (pc_ring[sb] != pc_ring[sa] + 32'd4 || taken_ring[sa] ||
                a.single_first || b.single_second)
                return 1'b0;
            wr = a.dest_wr && a.rd != 5'd0;
            raw1 = wr && b.src1_rd && b.rs1 == a.rd;
            raw2 = wr && b.src2_rd && b.rs2 == a.rd;
            // store data from an ALU result is forwarded, so it does not block
            bypass = a.alu && b.lsu && b.src2_rd && raw2 && !raw1;
            if ((raw1 || raw2) && !bypass)
                return 1'b0;
            if (!(a.alu || a.lsu || a.cfi) || !(b.alu || b.lsu || b.cfi))
                return 1'b0;
            return !(a.lsu && b.lsu) && !(a.cfi && b.cfi);
        endfunction

        function void note_packet(packet_t p);
            diq_pkg::result_t r;
            int unsigned      cap, take, h0, h1, slot;
            cap = (depth_limit > RING_SIZE) ? RING_SIZE : depth_limit;
            h0 = head;
            h1 = (head + 1) % RING_SIZE;
            take = 0;
            if (held != 0 && !p.consumer_stall) begin
                if (held < 2)
                    take = 1;
                else if (pair_all)
                    take = 2;
                else
                    take = pairable(h0, h1) ? 2 : 1;
            end
            r = '0;
            r.issue_count = diq_pkg::COUNT_W'(take);
            if (take >= 1) begin
                r.pc_a = pc_ring[h0];
                r.word_a = word_ring[h0];
            end
            if (take == 2) begin
                r.pc_b = pc_ring[h1];
                r.word_b = word_ring[h1];
            end
            head = (h0 + take) % RING_SIZE;
            held = held - take;
            if ((p.push_count == 2'd1 || p.push_count == 2'd2) &&
                held + p.push_count <= cap) begin
                slot = (head + held) % RING_SIZE;
                pc_ring[slot] = p.pc_first;
                word_ring[slot] = p.word_first;
                taken_ring[slot] = p.taken_first;
                held++;
                if (p.push_count == 2'd2) begin
                    slot = (head + held) % RING_SIZE;
                    pc_ring[slot] = p.pc_second;
                    word_ring[slot] = p.word_second;
                    taken_ring[slot] = p.taken_second;
                    held++;
                end
                r.accepted = 1'b1;
            end
            r.occupancy = diq_pkg::OCC_W'(held);
            expected_issues.insert(expected_issues.size(), r);
        endfunction

        function void check_issue(diq_pkg::result_t got);
            diq_pkg::result_t want;
            if (expected_issues.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: acc=%0d cnt=%0d occ=%0d",
                             got.accepted, got.issue_count, got.occupancy);
                return;
            end
            want = expected_issues.pop_front();
            if (got.accepted !== want.accepted || got.issue_count !== want.issue_count ||
                got.pc_a !== want.pc_a || got.word_a !== want.word_a ||
                got.pc_b !== want.pc_b || got.word_b !== want.word_b ||
                got.occupancy !== want.occupancy) begin
                errors++;
                if (errors <= 10) begin
                    $display("issue mismatch, expected: acc=%0d cnt=%0d a=%h/%h b=%h/%h occ=%0d",
                             want.accepted, want.issue_count, want.pc_a, want.word_a,
                             want.pc_b, want.word_b, want.occupancy);
                    $display("                  actual: acc=%0d cnt=%0d a=%h/%h b=%h/%h occ=%0d",
                             got.accepted, got.issue_count, got.pc_a, got.word_a,
                             got.pc_b, got.word_b, got.occupancy);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_issues.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [diq_pkg::CFG_IDX_W-1:0] cfg_index = diq_pkg::REG_DEPTH_LIMIT;
    logic [diq_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [diq_pkg::COUNT_W-1:0]   push_count = '0;
    logic [diq_pkg::XLEN-1:0]      pc_first = '0;
    logic [diq_pkg::XLEN-1:0]      word_first = '0;
    logic                          taken_first = 1'b0;
    logic [diq_pkg::XLEN-1:0]      pc_second = '0;
    logic [diq_pkg::XLEN-1:0]      word_second = '0;
    logic                          taken_second = 1'b0;
    logic                          consumer_stall = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          accepted;
    logic [diq_pkg::COUNT_W-1:0]   issue_count;
    logic [diq_pkg::XLEN-1:0]      issued_pc_a;
    logic [diq_pkg::XLEN-1:0]      issued_word_a;
    logic [diq_pkg::XLEN-1:0]      issued_pc_b;
    logic [diq_pkg::XLEN-1:0]      issued_word_b;
    logic [diq_pkg::OCC_W-1:0]     occupancy;

    queue_scoreboard board;

    // Per-cycle idle chances (percent) of the packet sender and the result sink
    int unsigned sender_idle_pct = 0;
    int unsigned sink_idle_pct = 0;

    // Running fetch address, so that most random packets continue a straight-line flow
    logic [diq_pkg::XLEN-1:0] next_pc = 32'h0000_1000;

    // Settings walked through, one per phase: depth limit, pair policy, packets
    int unsigned phase_limit[8]  = '{8, 1, 16, 0, 31, 3, 16, 12};
    bit          phase_policy[8] = '{0, 0, 1, 0, 1, 1, 0, 0};
    int unsigned phase_items[8]  = '{110, 110, 110, 40, 110, 110, 110, 110};

    dual_issue_decode_queue_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .push_count    (push_count),
        .pc_first      (pc_first),
        .word_first    (word_first),
        .taken_first   (taken_first),
        .pc_second     (pc_second),
        .word_second   (word_second),
        .taken_second  (taken_second),
        .consumer_stall(consumer_stall),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .issue_count   (issue_count),
        .issued_pc_a   (issued_pc_a),
        .issued_word_a (issued_word_a),
        .issued_pc_b   (issued_pc_b),
        .issued_word_b (issued_word_b),
        .occupancy     (occupancy)
    );

    always #2 clk = ~clk;

    // Drop the sink's ready at random; the chance is set per phase
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Sample both channels at the edge: a transfer happens where valid and ready
    // were both high just before it. Note the packet first so that the predictor
    // always runs ahead of the results it checks.
    always @(posedge clk) begin : transfer_monitor
        packet_t          pkt;
        diq_pkg::result_t seen;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                pkt.push_count = push_count;
                pkt.pc_first = pc_first;
                pkt.word_first = word_first;
                pkt.taken_first = taken_first;
                pkt.pc_second = pc_second;
                pkt.word_second = word_second;
                pkt.taken_second = taken_second;
                pkt.consumer_stall = consumer_stall;
                board.note_packet(pkt);
            end
            if (out_valid && out_ready) begin
                seen.accepted = accepted;
                seen.issue_count = issue_count;
                seen.pc_a = issued_pc_a;
                seen.word_a = issued_word_a;
                seen.pc_b = issued_pc_b;
                seen.word_b = issued_word_b;
                seen.occupancy = occupancy;
                board.check_issue(seen);
            end
        end
    end

    // Assemble an R-shaped encoding; immediates simply overlay the same bits
    function automatic logic [diq_pkg::XLEN-1:0] encode(logic [6:0] op, logic [4:0] rd,
                                                        logic [4:0] rs1, logic [4:0] rs2,
                                                        logic [2:0] f3, logic [6:0] f7);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    // Mostly low registers so that read-after-write hazards come up often
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(9) < 7) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    endfunction

    function automatic logic [diq_pkg::XLEN-1:0] random_instr();
        logic [diq_pkg::XLEN-1:0] w;
        logic [6:0]               f7;
        int unsigned              sel;
        w = $urandom;
        sel = $urandom_range(9);
        f7 = (sel < 6) ? diq_pkg::F7_BASE : (sel < 8) ? diq_pkg::F7_ALT :
             (sel == 8) ? diq_pkg::F7_MULDIV : 7'($urandom);
        w[11:7] = pick_reg();
        w[19:15] = pick_reg();
        w[24:20] = pick_reg();
        case ($urandom_range(15))
            0, 1, 15: begin
                w[6:0] = diq_pkg::OP_REG;
                w[31:25] = f7;
            end
            2, 3: begin
                w[6:0] = diq_pkg::OP_IMM;
                w[31:25] = f7;
            end
            4:  w[6:0] = $urandom_range(1) ? diq_pkg::OP_LUI : diq_pkg::OP_AUIPC;
            5, 6: w[6:0] = diq_pkg::OP_LOAD;
            7, 8: w[6:0] = diq_pkg::OP_STORE;
            9:  w[6:0] = diq_pkg::OP_BRANCH;
            10: w[6:0] = diq_pkg::OP_JAL;
            11: w[6:0] = diq_pkg::OP_JALR;
            12: w[6:0] = $urandom_range(1) ? diq_pkg::OP_SYSTEM : diq_pkg::OP_FENCE;
            13: w[1:0] = 2'($urandom_range(2));
            default: ;
        endcase
        return w;
    endfunction

    // Mostly a straight-line flow; now and then a jump, a wrap near the top of
    // the address space, or a second PC that does not follow the first
    function automatic packet_t random_packet();
        packet_t     p;
        int unsigned r;
        r = $urandom_range(19);
        p.push_count = (r == 0) ? 2'd0 : (r == 1) ? 2'd3 : (r < 9) ? 2'd1 : 2'd2;
        if ($urandom_range(99) < 15)
            next_pc = ($urandom_range(9) == 0) ? 32'hFFFF_FFF8 : $urandom;
        p.pc_first = next_pc;
        p.word_first = random_instr();
        p.taken_first = $urandom_range(99) < 15;
        p.pc_second = ($urandom_range(9) == 0) ? $urandom : p.pc_first + 32'd4;
        p.word_second = random_instr();
        p.taken_second = $urandom_range(99) < 15;
        p.consumer_stall = $urandom_range(99) < 35;
        if (p.push_count == 2'd1)
            next_pc = p.pc_first + 32'd4;
        else if (p.push_count == 2'd2)
            next_pc = p.pc_second + 32'd4;
        return p;
    endfunction

    // Offer one packet, with random idle cycles ahead of it; hold it until transfer
    task automatic send_packet(packet_t p);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        push_count <= p.push_count;
        pc_first <= p.pc_first;
        word_first <= p.word_first;
        taken_first <= p.taken_first;
        pc_second <= p.pc_second;
        word_second <= p.word_second;
        taken_second <= p.taken_second;
        consumer_stall <= p.consumer_stall;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Load two entries while the consumer stalls, then drain them with a plain
    // empty packet and with a push count of three, which must be treated as none.
    task automatic pair_case(logic [diq_pkg::XLEN-1:0] pc_a, logic [diq_pkg::XLEN-1:0] word_a,
                             logic taken_a, logic [diq_pkg::XLEN-1:0] word_b);
        packet_t p;
        p.push_count = 2'd2;
        p.pc_first = pc_a;
        p.word_first = word_a;
        p.taken_first = taken_a;
        p.pc_second = pc_a + 32'd4;
        p.word_second = word_b;
        p.taken_second = 1'b1;
        p.consumer_stall = 1'b1;
        send_packet(p);
        p.push_count = 2'd0;
        p.consumer_stall = 1'b0;
        send_packet(p);
        p.push_count = 2'd3;
        p.pc_first = ~pc_a;
        p.word_first = ~word_a;
        send_packet(p);
    endtask

    // Stop offering and wait until every expected result has come out, then
    // let the back end settle before anything else changes
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges; keep the enable high across them
    task automatic write_settings(logic [diq_pkg::CFG_W-1:0] limit, logic policy);
        cfg_we <= 1'b1;
        cfg_index <= diq_pkg::REG_DEPTH_LIMIT;
        cfg_data <= limit;
        board.configure(diq_pkg::REG_DEPTH_LIMIT, limit);
        @(posedge clk);
        cfg_index <= diq_pkg::REG_PAIR_POLICY;
        cfg_data <= diq_pkg::CFG_W'(policy);
        board.configure(diq_pkg::REG_PAIR_POLICY, diq_pkg::CFG_W'(policy));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 8; ph++) begin
            // sender eager and sink lazy, then the other way round, then no idling
            if (ph < 3) begin
                sender_idle_pct = 7;
                sink_idle_pct = 46;
            end else if (ph < 6) begin
                sender_idle_pct = 46;
                sink_idle_pct = 7;
            end else begin
                sender_idle_pct = 0;
                sink_idle_pct = 0;
            end
            write_settings(diq_pkg::CFG_W'(phase_limit[ph]), phase_policy[ph]);

            if (ph == 0) begin
                // independent ALU ops across the address wrap: pair
                pair_case(32'hFFFF_FFFC,
                          encode(diq_pkg::OP_REG, 5'd1, 5'd2, 5'd3, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE),
                          1'b0,
                          encode(diq_pkg::OP_IMM, 5'd4, 5'd5, 5'd6, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE));
                // second reads the first's destination: hold back
                pair_case(32'h0000_0100,
                          encode(diq_pkg::OP_REG, 5'd1, 5'd2, 5'd3, diq_pkg::F3_ADD,
                                 diq_pkg::F7_ALT),
                          1'b0,
                          encode(diq_pkg::OP_REG, 5'd5, 5'd1, 5'd2, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE));
                // ALU result only feeds store data: bypassed, pair
                pair_case(32'h0000_0200,
                          encode(diq_pkg::OP_IMM, 5'd7, 5'd2, 5'd3, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE),
                          1'b0,
                          encode(diq_pkg::OP_STORE, 5'd0, 5'd2, 5'd7, 3'd2,
                                 diq_pkg::F7_BASE));
                // first predicted taken
                pair_case(32'h0000_0300,
                          encode(diq_pkg::OP_REG, 5'd1, 5'd2, 5'd3, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE),
                          1'b1,
                          encode(diq_pkg::OP_IMM, 5'd4, 5'd5, 5'd6, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE));
                // indirect jump first
                pair_case(32'h0000_0400,
                          encode(diq_pkg::OP_JALR, 5'd0, 5'd1, 5'd0, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE),
                          1'b0,
                          encode(diq_pkg::OP_REG, 5'd4, 5'd5, 5'd6, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE));
                // two memory ops
                pair_case(32'h0000_0500,
                          encode(diq_pkg::OP_LOAD, 5'd1, 5'd2, 5'd0, 3'd2, diq_pkg::F7_BASE),
                          1'b0,
                          encode(diq_pkg::OP_STORE, 5'd0, 5'd3, 5'd4, 3'd2,
                                 diq_pkg::F7_BASE));
                // two control-flow ops
                pair_case(32'h0000_0600,
                          encode(diq_pkg::OP_BRANCH, 5'd0, 5'd1, 5'd2, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE),
                          1'b0,
                          encode(diq_pkg::OP_JAL, 5'd0, 5'd0, 5'd0, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE));
                // unknown all-ones word followed by a system op
                pair_case(32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
                          encode(diq_pkg::OP_SYSTEM, 5'd0, 5'd0, 5'd0, diq_pkg::F3_ADD,
                                 diq_pkg::F7_BASE));
            end

            for (int n = 0; n < phase_items[ph]; n++)
                send_packet(random_packet());
            drain();
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("dual_issue_decode_queue_unit_test passed");
        else
            $display("dual_issue_decode_queue_unit_test failed");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("dual_issue_decode_queue_unit_test failed");
        $finish;
    end

endmodule
